@@ hdl/fdr_pkg.sv @@
package fdr_pkg;

  localparam int WFRAC         = 30;
  localparam int COS_FRAC_BITS = 15;
  localparam int COS_W         = 16;
  localparam int ETA_W         = 16;
  localparam int REFL_W        = 16;
  localparam int ADDR_W        = 2;

  // Q30 operand widths
  localparam int CI_W   = WFRAC + 1;           // up to and including 1.0
  localparam int RAD_W  = 2 * WFRAC + 1;       // radicand up to 2^60
  localparam int PROD_W = ETA_W + CI_W;        // eta times a Q30 value
  localparam int SQRT_STEPS = WFRAC + 1;

  localparam logic [ADDR_W-1:0] REG_ETA_OUTSIDE = 2'd0;
  localparam logic [ADDR_W-1:0] REG_ETA_INSIDE  = 2'd1;

  localparam logic [ETA_W-1:0] ETA_OUTSIDE_RST = 16'd4096;
  localparam logic [ETA_W-1:0] ETA_INSIDE_RST  = 16'd6144;

  localparam logic [CI_W-1:0]  ONE_W  = CI_W'(1) << WFRAC;
  localparam logic [RAD_W-1:0] ONE_SQ = RAD_W'(1) << (2 * WFRAC);

  typedef struct packed {
    logic             tir;
    logic [CI_W-1:0]  ci;
    logic [ETA_W-1:0] ei;
    logic [ETA_W-1:0] et;
  } side_t;

endpackage

@@ hdl/fresnel_dielectric_reflectance_core.sv @@
// Fresnel reflectance of a smooth dielectric boundary, unpolarised light.
// Input: pulse start with cos_incident (signed Q1.15) on the same cycle; a beat
// is taken whenever start is high and busy is low. busy is high only in reset,
// so a new beat may be given every cycle.
// Output: done is high for one cycle with reflectance (unsigned Q0.16,
// saturated) and total_internal. The receiver cannot hold results off; the
// pipeline never waits on it.
// Throughput: one beat per cycle, set by the fully pipelined datapath: two
// 31-stage square roots and three 30-stage dividers, one bit per stage.
// Configuration: cfg_we/cfg_addr/cfg_data write eta_outside (0) and
// eta_inside (1), unsigned Q4.12; write only while no beat is in flight.
// Reset (rst, synchronous) restores the indices to 1.0 and 1.5 and empties the
// pipeline; beats in flight are dropped.
module fresnel_dielectric_reflectance_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [fdr_pkg::COS_W-1:0]     cos_incident,
  output logic                          done,
  output logic [fdr_pkg::REFL_W-1:0]    reflectance,
  output logic                          total_internal,
  input  logic                          cfg_we,
  input  logic [fdr_pkg::ADDR_W-1:0]    cfg_addr,
  input  logic [fdr_pkg::ETA_W-1:0]     cfg_data
);

  localparam int EW  = fdr_pkg::ETA_W;
  localparam int CW  = fdr_pkg::CI_W;
  localparam int PW  = fdr_pkg::PROD_W;
  localparam int RW  = fdr_pkg::RAD_W;
  localparam int WF  = fdr_pkg::WFRAC;
  localparam int SHW = $bits(fdr_pkg::side_t);
  localparam int CI_SH = fdr_pkg::WFRAC - fdr_pkg::COS_FRAC_BITS;

  logic [EW-1:0] eta_outside, eta_inside;

  always_ff @(posedge clk) begin
    if (rst) begin
      eta_outside <= fdr_pkg::ETA_OUTSIDE_RST;
      eta_inside  <= fdr_pkg::ETA_INSIDE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        fdr_pkg::REG_ETA_OUTSIDE: eta_outside <= cfg_data;
        fdr_pkg::REG_ETA_INSIDE:  eta_inside  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // ---------------- front end ----------------
  logic          accept, entering;
  logic          v0, v1, v2, v3;
  logic [15:0]   cos0;
  logic [EW-1:0] ei0, et0, ei1, et1, ei2, et2, ei3, et3;
  logic [CW-1:0] ci1, ci2, ci3;
  logic [16:0]   mag;
  logic [47:0]   ci_wide;
  logic [2*CW-1:0] sq2;
  logic [RW-1:0] rad3;

  assign accept   = start && !busy;
  assign entering = (cos_incident != '0) && !cos_incident[fdr_pkg::COS_W-1];

  assign mag     = cos0[15] ? (17'd65536 - {1'b0, cos0}) : {1'b0, cos0};
  assign ci_wide = 48'(mag) << CI_SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    cos0 <= cos_incident;
    ei0  <= entering ? eta_outside : eta_inside;
    et0  <= entering ? eta_inside  : eta_outside;
    ci1  <= (ci_wide > 48'(fdr_pkg::ONE_W)) ? fdr_pkg::ONE_W : ci_wide[CW-1:0];
    ei1  <= ei0;
    et1  <= et0;
    sq2  <= (2*CW)'(ci1) * (2*CW)'(ci1);
    ci2  <= ci1;
    ei2  <= ei1;
    et2  <= et1;
    rad3 <= fdr_pkg::ONE_SQ - RW'(sq2);
    ci3  <= ci2;
    ei3  <= ei2;
    et3  <= et2;
  end

  // ---------------- sin of incidence ----------------
  fdr_pkg::side_t side3, sa_o;
  logic          sa_v;
  logic [CW-1:0] sin_i;

  always_comb begin
    side3     = '0;
    side3.ci  = ci3;
    side3.ei  = ei3;
    side3.et  = et3;
  end

  fdr_isqrt #(.SW(SHW)) u_sqrt_sin (
    .clk(clk), .rst(rst), .in_valid(v3), .rad(rad3), .in_side(side3),
    .out_valid(sa_v), .root(sin_i), .out_side(sa_o)
  );

  // ---------------- Snell ----------------
  logic           v4, v5;
  logic [PW-1:0]  p4, p5;
  fdr_pkg::side_t s4, s4_tir, s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v4 <= sa_v;
      v5 <= v4;
    end
  end

  always_comb begin
    s4_tir     = s4;
    // transmitted sine at or above one, or no far index
    s4_tir.tir = (s4.et == '0) || (p4 >= PW'({s4.et, {WF{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    p4 <= PW'(sa_o.ei) * PW'(sin_i);
    s4 <= sa_o;
    p5 <= p4;
    s5 <= s4_tir;
  end

  logic           sb_v;
  logic [WF-1:0]  sin_t;
  fdr_pkg::side_t sb_o;

  fdr_div #(.DW(EW), .STEPS(WF), .SW(SHW)) u_div_snell (
    .clk(clk), .rst(rst), .in_valid(v5),
    .rem0(p5[WF+EW-1:WF]), .low(p5[WF-1:0]), .den(s5.et), .in_side(s5),
    .out_valid(sb_v), .quot(sin_t), .out_side(sb_o)
  );

  // ---------------- cos of transmission ----------------
  logic           v6, v7;
  logic [2*WF-1:0] st6;
  logic [RW-1:0]  rad7;
  fdr_pkg::side_t s6, s7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v6 <= sb_v;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    st6  <= (2*WF)'(sin_t) * (2*WF)'(sin_t);
    s6   <= sb_o;
    rad7 <= fdr_pkg::ONE_SQ - RW'(st6);
    s7   <= s6;
  end

  logic           sc_v;
  logic [CW-1:0]  cos_t;
  fdr_pkg::side_t sc_o;

  fdr_isqrt #(.SW(SHW)) u_sqrt_cos (
    .clk(clk), .rst(rst), .in_valid(v7), .rad(rad7), .in_side(s7),
    .out_valid(sc_v), .root(cos_t), .out_side(sc_o)
  );

  // ---------------- amplitude ratio operands ----------------
  logic          v8, v9, v10;
  logic          tir8, tir9, tir10;
  logic [PW-1:0] a8, b8, c8, d8, nab9, ncd9;
  logic [PW:0]   sab9, scd9, sab10, scd10, nab10, ncd10;
  logic          satab10, satcd10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else begin
      v8  <= sc_v;
      v9  <= v8;
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    a8    <= PW'(sc_o.et) * PW'(sc_o.ci);
    b8    <= PW'(sc_o.ei) * PW'(cos_t);
    c8    <= PW'(sc_o.ei) * PW'(sc_o.ci);
    d8    <= PW'(sc_o.et) * PW'(cos_t);
    tir8  <= sc_o.tir;
    sab9  <= (PW+1)'(a8) + (PW+1)'(b8);
    scd9  <= (PW+1)'(c8) + (PW+1)'(d8);
    nab9  <= (a8 >= b8) ? (a8 - b8) : (b8 - a8);
    ncd9  <= (c8 >= d8) ? (c8 - d8) : (d8 - c8);
    tir9  <= tir8;
    sab10 <= sab9;
    scd10 <= scd9;
    nab10 <= (PW+1)'(nab9);
    ncd10 <= (PW+1)'(ncd9);
    // covers a zero denominator too: the ratio is then one
    satab10 <= (PW+1)'(nab9) >= sab9;
    satcd10 <= (PW+1)'(ncd9) >= scd9;
    tir10   <= tir9;
  end

  logic          dp_v, dq_v, dp_tir, dp_sat, dq_sat;
  logic [WF-1:0] q_par, q_per;

  fdr_div #(.DW(PW+1), .STEPS(WF), .SW(2)) u_div_par (
    .clk(clk), .rst(rst), .in_valid(v10),
    .rem0(nab10), .low('0), .den(sab10), .in_side({tir10, satab10}),
    .out_valid(dp_v), .quot(q_par), .out_side({dp_tir, dp_sat})
  );

  fdr_div #(.DW(PW+1), .STEPS(WF), .SW(1)) u_div_per (
    .clk(clk), .rst(rst), .in_valid(v10),
    .rem0(ncd10), .low('0), .den(scd10), .in_side(satcd10),
    .out_valid(dq_v), .quot(q_per), .out_side(dq_sat)
  );

  // ---------------- squares, mean, rounding ----------------
  logic            v11, v12, tir11, tir12;
  logic [CW-1:0]   rpar11, rper11;
  logic [2*CW-1:0] sqp12, sqq12;
  logic [2*CW:0]   sum;
  logic [2*CW-45:0] rnd;
  logic [fdr_pkg::REFL_W-1:0] refl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11  <= 1'b0;
      v12  <= 1'b0;
      done <= 1'b0;
    end else begin
      v11  <= dp_v && dq_v;
      v12  <= v11;
      done <= v12;
    end
  end

  assign sum  = (2*CW+1)'(sqp12) + (2*CW+1)'(sqq12) + ((2*CW+1)'(1) << 44);
  assign rnd  = sum[2*CW:45];
  assign refl = (rnd > (2*CW-44)'(16'hFFFF)) ? 16'hFFFF : rnd[fdr_pkg::REFL_W-1:0];

  always_ff @(posedge clk) begin
    rpar11 <= dp_sat ? fdr_pkg::ONE_W : CW'(q_par);
    rper11 <= dq_sat ? fdr_pkg::ONE_W : CW'(q_per);
    tir11  <= dp_tir;
    sqp12  <= (2*CW)'(rpar11) * (2*CW)'(rpar11);
    sqq12  <= (2*CW)'(rper11) * (2*CW)'(rper11);
    tir12  <= tir11;
    reflectance    <= tir12 ? 16'hFFFF : refl;
    total_internal <= tir12;
  end

endmodule

@@ hdl/fdr_isqrt.sv @@
module fdr_isqrt #(
  parameter int SW = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [fdr_pkg::RAD_W-1:0]        rad,
  input  logic [SW-1:0]                    in_side,
  output logic                             out_valid,
  output logic [fdr_pkg::CI_W-1:0]         root,
  output logic [SW-1:0]                    out_side
);

  localparam int N  = fdr_pkg::SQRT_STEPS;
  localparam int RW = fdr_pkg::RAD_W + 1;

  logic [RW-1:0] v_q   [0:N];
  logic [RW-1:0] res_q [0:N];
  logic [SW-1:0] side_q[0:N];
  logic          valid_q[0:N];
  logic [RW-1:0] bitv  [0:N-1];
  logic [RW-1:0] trial [0:N-1];

  always_comb begin
    for (int s = 0; s < N; s++) begin
      bitv[s]  = RW'(1) << (2 * (N - 1 - s));
      trial[s] = res_q[s] + bitv[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= N; s++) valid_q[s] <= 1'b0;
    end else begin
      valid_q[0] <= in_valid;
      for (int s = 0; s < N; s++) valid_q[s+1] <= valid_q[s];
    end
  end

  // one root bit per stage, largest first
  always_ff @(posedge clk) begin
    v_q[0]    <= RW'(rad);
    res_q[0]  <= '0;
    side_q[0] <= in_side;
    for (int s = 0; s < N; s++) begin
      side_q[s+1] <= side_q[s];
      if (v_q[s] >= trial[s]) begin
        v_q[s+1]   <= v_q[s] - trial[s];
        res_q[s+1] <= (res_q[s] >> 1) + bitv[s];
      end else begin
        v_q[s+1]   <= v_q[s];
        res_q[s+1] <= res_q[s] >> 1;
      end
    end
  end

  assign out_valid = valid_q[N];
  assign root      = res_q[N][fdr_pkg::CI_W-1:0];
  assign out_side  = side_q[N];

endmodule

@@ hdl/fdr_div.sv @@
module fdr_div #(
  parameter int DW    = 16,
  parameter int STEPS = 30,
  parameter int SW    = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [DW-1:0]    rem0,
  input  logic [STEPS-1:0] low,
  input  logic [DW-1:0]    den,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [STEPS-1:0] quot,
  output logic [SW-1:0]    out_side
);

  logic [DW-1:0]    rem_q [0:STEPS];
  logic [STEPS-1:0] q_q   [0:STEPS];
  logic [STEPS-1:0] low_q [0:STEPS];
  logic [DW-1:0]    den_q [0:STEPS];
  logic [SW-1:0]    side_q[0:STEPS];
  logic             valid_q[0:STEPS];
  logic [DW:0]      sh    [0:STEPS-1];

  always_comb begin
    for (int s = 0; s < STEPS; s++) begin
      sh[s] = {rem_q[s], low_q[s][STEPS-1-s]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= STEPS; s++) valid_q[s] <= 1'b0;
    end else begin
      valid_q[0] <= in_valid;
      for (int s = 0; s < STEPS; s++) valid_q[s+1] <= valid_q[s];
    end
  end

  // restoring division, one quotient bit per stage
  always_ff @(posedge clk) begin
    rem_q[0]  <= rem0;
    q_q[0]    <= '0;
    low_q[0]  <= low;
    den_q[0]  <= den;
    side_q[0] <= in_side;
    for (int s = 0; s < STEPS; s++) begin
      low_q[s+1]  <= low_q[s];
      den_q[s+1]  <= den_q[s];
      side_q[s+1] <= side_q[s];
      if (sh[s] >= {1'b0, den_q[s]}) begin
        rem_q[s+1] <= DW'(sh[s] - {1'b0, den_q[s]});
        q_q[s+1]   <= {q_q[s][STEPS-2:0], 1'b1};
      end else begin
        rem_q[s+1] <= sh[s][DW-1:0];
        q_q[s+1]   <= {q_q[s][STEPS-2:0], 1'b0};
      end
    end
  end

  assign out_valid = valid_q[STEPS];
  assign quot      = q_q[STEPS];
  assign out_side  = side_q[STEPS];

endmodule

@@ dv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [fdr_pkg::ADDR_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [fdr_pkg::ADDR_W-1:0] REG_UNUSED_3 = 2'd3;
  localparam int LATENCY = 140;

  typedef struct {
    logic [fdr_pkg::REFL_W-1:0] refl;
    logic                       tir;
  } refl_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [fdr_pkg::COS_W-1:0] cos_incident = '0;
  logic done;
  logic [fdr_pkg::REFL_W-1:0] reflectance;
  logic total_internal;
  logic cfg_we = 1'b0;
  logic [fdr_pkg::ADDR_W-1:0] cfg_addr = '0;
  logic [fdr_pkg::ETA_W-1:0] cfg_data = '0;

  fresnel_dielectric_reflectance_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cos_incident(cos_incident),
    .done(done), .reflectance(reflectance), .total_internal(total_internal),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  logic [fdr_pkg::COS_W-1:0] cos_pending[$];
  refl_beat_t       refl_expected[$];
  logic [63:0]      eta_out_model = 64'd4096;
  logic [63:0]      eta_in_model  = 64'd6144;
  bit               quiet = 1'b0;
  int               mismatches = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // |p-q|/(p+q) in Q30, one when the sum is zero or the ratio reaches one
  function automatic logic [63:0] amplitude_ratio(logic [63:0] p, logic [63:0] q);
    logic [63:0] den, rem, quo;
    den = p + q;
    rem = (p >= q) ? p - q : q - p;
    quo = 0;
    if (den == 0 || rem >= den) return 64'd1 << fdr_pkg::WFRAC;
    for (int i = 0; i < fdr_pkg::WFRAC; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic refl_beat_t fresnel_predict(logic [fdr_pkg::COS_W-1:0] raw);
    refl_beat_t r;
    logic [63:0] one, mag, ei, et, ci, sin_i, sin_t, cos_t, rpar, rper, sum;
    one = 64'd1 << fdr_pkg::WFRAC;
    mag = raw[fdr_pkg::COS_W-1] ? 64'h10000 - raw : {48'd0, raw};
    if (raw != 0 && !raw[fdr_pkg::COS_W-1]) begin
      ei = eta_out_model;
      et = eta_in_model;
    end else begin
      ei = eta_in_model;
      et = eta_out_model;
    end
    ci = mag << (fdr_pkg::WFRAC - fdr_pkg::COS_FRAC_BITS);
    if (ci > one) ci = one;
    sin_i = int_sqrt((one << fdr_pkg::WFRAC) - ci * ci);
    r.refl = 16'hFFFF;
    r.tir = 1'b1;
    if (et == 0) return r;
    sin_t = (ei * sin_i) / et;
    if (sin_t >= one) return r;
    cos_t = int_sqrt((one << fdr_pkg::WFRAC) - sin_t * sin_t);
    rpar = amplitude_ratio(et * ci, ei * cos_t);
    rper = amplitude_ratio(ei * ci, et * cos_t);
    sum = (rpar * rpar + rper * rper + (64'd1 << 44)) >> 45;
    r.refl = (sum > 65535) ? 16'hFFFF : sum[15:0];
    r.tir = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // driver: predict on every accepted beat, then offer the next
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) refl_expected.push_back(fresnel_predict(cos_incident));
      if (start && busy) begin
        start <= 1'b1;
      end else if (cos_pending.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
        start <= 1'b1;
        cos_incident <= cos_pending.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    refl_beat_t e;
    if (!rst && done) begin
      if (refl_expected.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = refl_expected.pop_front();
        if (reflectance !== e.refl)
          report_mismatch($sformatf("reflectance %0d, expected %0d", reflectance, e.refl));
        if (total_internal !== e.tir)
          report_mismatch($sformatf("total_internal %0b, expected %0b", total_internal,
                                    e.tir));
      end
    end
  end

  task automatic write_eta(logic [fdr_pkg::ADDR_W-1:0] idx,
                           logic [fdr_pkg::ETA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    if (idx == fdr_pkg::REG_ETA_OUTSIDE) eta_out_model = val;
    else if (idx == fdr_pkg::REG_ETA_INSIDE) eta_in_model = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold until every beat has gone in and come out, then let the pipe drain
  task automatic drain;
    while (cos_pending.size() > 0 || start) @(posedge clk);
    while (refl_expected.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic random_beats(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: cos_pending.push_back(16'($urandom_range(32767)));
        1: cos_pending.push_back(16'h8000 | 16'($urandom_range(32767)));
        2: cos_pending.push_back(16'($urandom_range(600)));
        default: cos_pending.push_back(16'($urandom));
      endcase
    end
  endtask

  logic [fdr_pkg::ETA_W-1:0] eta_sets[8][2] = '{
    '{16'd4096, 16'd6144}, '{16'd6144, 16'd4096}, '{16'd1, 16'd65535},
    '{16'd65535, 16'd1}, '{16'd4096, 16'd4096}, '{16'd5000, 16'd0},
    '{16'd0, 16'd5000}, '{16'd65535, 16'd65535}
  };

  logic [fdr_pkg::COS_W-1:0] directed[18] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
    16'h8000, 16'h8001, 16'h4000, 16'hC000, 16'h5A82, 16'hA57E, 16'h0100, 16'hFF00,
    16'h7000, 16'h1000, 16'hF000, 16'h0002, 16'h2000, 16'hE000};

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) cos_pending.push_back(directed[i]);
    random_beats(60);
    drain();
    write_eta(REG_UNUSED_2, 16'($urandom));
    write_eta(REG_UNUSED_3, 16'($urandom));
    for (int p = 0; p < 10; p++) begin
      if (p < 8) begin
        write_eta(fdr_pkg::REG_ETA_OUTSIDE, eta_sets[p][0]);
        write_eta(fdr_pkg::REG_ETA_INSIDE, eta_sets[p][1]);
      end else begin
        write_eta(fdr_pkg::REG_ETA_OUTSIDE, 16'($urandom_range(65535, 1)));
        write_eta(fdr_pkg::REG_ETA_INSIDE, 16'($urandom_range(65535, 1)));
      end
      foreach (directed[i]) cos_pending.push_back(directed[i]);
      quiet = (p == 3);
      random_beats(120);
      drain();
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
